### rtl/hvld_pkg.sv
// Shared types, constants and bit-mapping functions for the Hamming decoder.
package hvld_pkg;

  localparam int CODE_BITS = 64;
  localparam int LEN_W     = 7;
  localparam int SYN_W     = 7;
  localparam int DATA_W    = 57;
  localparam int SHAMT_W   = 6;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_CORRECTED = 2'd1,
    STAT_REJECTED  = 2'd2
  } status_t;

  // Stage 2 -> stage 3: masked word with its syndrome
  typedef struct packed {
    logic                 vld;
    logic [CODE_BITS-1:0] word;
    logic [LEN_W-1:0]     len;
    logic [SHAMT_W-1:0]   dlen;
    logic [SYN_W-1:0]     syn;
  } syn_stage_t;

  // Stage 3 -> stage 4: compacted data (bit-reversed) and alignment shift
  typedef struct packed {
    logic                 vld;
    logic [DATA_W-1:0]    data_rev;
    logic [SHAMT_W-1:0]   shamt;
    status_t              status;
    logic [SYN_W-1:0]     syn;
  } fix_stage_t;

  function automatic logic is_pow2(int v);
    return (v != 0) && ((v & (v - 1)) == 0);
  endfunction

  // Positions p (1-based) whose index has bit b set
  function automatic logic [CODE_BITS-1:0] cover_mask(int b);
    logic [CODE_BITS-1:0] m;
    m = '0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      m[p-1] = ((p >> b) & 1) != 0;
    end
    return m;
  endfunction

  // Number of powers of two not above n
  function automatic logic [LEN_W-1:0] parity_count(logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (n >= LEN_W'(1 << i)) begin
        cnt = cnt + LEN_W'(1);
      end
    end
    return cnt;
  endfunction

  // Fixed wiring: idx-th data position lands at bit DATA_W-1-idx
  function automatic logic [DATA_W-1:0] compact_rev(logic [CODE_BITS-1:0] w);
    logic [DATA_W-1:0] d;
    int                idx;
    d   = '0;
    idx = 0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (!is_pow2(p)) begin
        d[DATA_W-1-idx] = w[p-1];
        idx++;
      end
    end
    return d;
  endfunction

endpackage

### rtl/hvld_front.sv
// Stages 1-2: length clamp, word masking, data count and syndrome.
module hvld_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [hvld_pkg::CODE_BITS-1:0] codeword,
  input  logic [hvld_pkg::LEN_W-1:0]     code_length,
  output hvld_pkg::syn_stage_t           s2
);
  import hvld_pkg::*;

  logic [LEN_W-1:0]     n_sat;
  logic [CODE_BITS-1:0] len_mask;
  logic [LEN_W-1:0]     dlen_full;
  logic [SYN_W-1:0]     syn_c;

  logic                 s1_vld_r;
  logic [CODE_BITS-1:0] s1_word_r;
  logic [LEN_W-1:0]     s1_len_r;
  logic [SHAMT_W-1:0]   s1_dlen_r;

  logic                 s2_vld_r;
  logic [CODE_BITS-1:0] s2_word_r;
  logic [LEN_W-1:0]     s2_len_r;
  logic [SHAMT_W-1:0]   s2_dlen_r;
  logic [SYN_W-1:0]     s2_syn_r;

  always_comb begin
    n_sat = (code_length > LEN_W'(CODE_BITS)) ? LEN_W'(CODE_BITS) : code_length;
    if (n_sat == LEN_W'(CODE_BITS)) begin
      len_mask = '1;
    end else begin
      len_mask = (CODE_BITS'(1) << n_sat[SHAMT_W-1:0]) - CODE_BITS'(1);
    end
    dlen_full = n_sat - parity_count(n_sat);
  end

  // syndrome bit b = parity over positions covered by 2^b
  always_comb begin
    for (int b = 0; b < SYN_W; b++) begin
      syn_c[b] = ^(s1_word_r & cover_mask(b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_word_r <= codeword & len_mask;
    s1_len_r  <= n_sat;
    s1_dlen_r <= dlen_full[SHAMT_W-1:0];
    s2_word_r <= s1_word_r;
    s2_len_r  <= s1_len_r;
    s2_dlen_r <= s1_dlen_r;
    s2_syn_r  <= syn_c;
  end

  assign s2.vld  = s2_vld_r;
  assign s2.word = s2_word_r;
  assign s2.len  = s2_len_r;
  assign s2.dlen = s2_dlen_r;
  assign s2.syn  = s2_syn_r;

endmodule

### rtl/hvld_fix.sv
// Stage 3: single-bit correction, status and data-position compaction.
module hvld_fix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 correct_en,
  input  hvld_pkg::syn_stage_t s2,
  output hvld_pkg::fix_stage_t s3
);
  import hvld_pkg::*;

  logic                 has_err;
  logic                 do_flip;
  logic [SHAMT_W-1:0]   flip_pos;
  logic [CODE_BITS-1:0] word_fix;
  status_t              status_c;
  logic [DATA_W-1:0]    data_rev_c;

  logic                 vld_r;
  logic [DATA_W-1:0]    data_rev_r;
  logic [SHAMT_W-1:0]   shamt_r;
  status_t              status_r;
  logic [SYN_W-1:0]     syn_r;

  always_comb begin
    has_err  = (s2.syn != '0);
    // syndrome past the length leaves the word alone
    do_flip  = has_err && correct_en && (s2.syn <= s2.len);
    flip_pos = SHAMT_W'(s2.syn - SYN_W'(1));
    word_fix = s2.word ^ (do_flip ? (CODE_BITS'(1) << flip_pos) : '0);
    priority if (!has_err) begin
      status_c = STAT_OK;
    end else if (correct_en) begin
      status_c = STAT_CORRECTED;
    end else begin
      status_c = STAT_REJECTED;
    end
    data_rev_c = (status_c == STAT_REJECTED) ? '0 : compact_rev(word_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s2.vld;
    end
  end

  always_ff @(posedge clk) begin
    data_rev_r <= data_rev_c;
    shamt_r    <= SHAMT_W'(DATA_W) - s2.dlen;
    status_r   <= status_c;
    syn_r      <= s2.syn;
  end

  assign s3.vld      = vld_r;
  assign s3.data_rev = data_rev_r;
  assign s3.shamt    = shamt_r;
  assign s3.status   = status_r;
  assign s3.syn      = syn_r;

endmodule

### rtl/hvld_pack.sv
// Stage 4: right-align the m data bits and register the result item.
module hvld_pack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hvld_pkg::fix_stage_t        s3,
  output logic                        out_valid,
  output logic [hvld_pkg::DATA_W-1:0] data_word,
  output logic [1:0]                  status,
  output logic [hvld_pkg::SYN_W-1:0]  syndrome_value
);
  import hvld_pkg::*;

  logic                 vld_r;
  logic [DATA_W-1:0]    data_r;
  status_t              status_r;
  logic [SYN_W-1:0]     syn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s3.vld;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= s3.data_rev >> s3.shamt;
    status_r <= s3.status;
    syn_r    <= s3.syn;
  end

  assign out_valid      = vld_r;
  assign data_word      = data_r;
  assign status         = status_r;
  assign syndrome_value = syn_r;

endmodule

### rtl/hamming_variable_length_decoder.sv
// Top level: variable-length Hamming SEC decoder, four-stage pipeline.
// An accepted item is registered through stages 1, 2, 3 and 4 in turn before its out_valid strobe.
// Throughput: one item per cycle; busy is always low since the four register stages
// each pass one item per clock and the receiver takes every result.
// Reset (rst_n low, synchronous): pipeline valid bits clear, correct_enable returns to 1.
module hamming_variable_length_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           start,
  output logic                           busy,
  input  logic [hvld_pkg::CODE_BITS-1:0] in_codeword,
  input  logic [hvld_pkg::LEN_W-1:0]     in_code_length,
  // configuration: correct_enable
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  // result channel, one-cycle strobe
  output logic                           out_valid,
  output logic [hvld_pkg::DATA_W-1:0]    out_data_word,
  output logic [1:0]                     out_status,
  output logic [hvld_pkg::SYN_W-1:0]     out_syndrome_value
);
  import hvld_pkg::*;

  logic       correct_en_r;
  logic       in_valid;
  syn_stage_t s2;
  fix_stage_t s3;

  // Every stage advances each clock, so the front end never pushes back.
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // correct_enable: 1 fixes the syndrome-named bit, 0 rejects bad words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      correct_en_r <= 1'b1;
    end else if (cfg_we) begin
      correct_en_r <= cfg_wdata;
    end
  end

  // Stages 1-2: clamp n to 64, drop bits past n, count data bits,
  // then fold the word into a 7-bit syndrome (XOR of set positions).
  hvld_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .codeword    (in_codeword),
    .code_length (in_code_length),
    .s2          (s2)
  );

  // Stage 3: flip the named bit when allowed and in range, pick status,
  // gather the non-power-of-two positions into a reversed data vector.
  hvld_fix u_fix (
    .clk        (clk),
    .rst_n      (rst_n),
    .correct_en (correct_en_r),
    .s2         (s2),
    .s3         (s3)
  );

  // Stage 4: shift right by 57-m so the first data position sits at bit m-1.
  hvld_pack u_pack (
    .clk            (clk),
    .rst_n          (rst_n),
    .s3             (s3),
    .out_valid      (out_valid),
    .data_word      (out_data_word),
    .status         (out_status),
    .syndrome_value (out_syndrome_value)
  );

endmodule
